[src/gaps_pkg.sv]
package gaps_pkg;

	localparam int MAX_WIDTH     = 16;
	localparam int MAX_HEIGHT    = 16;
	localparam int COST_STRAIGHT = 10;
	localparam int COST_DIAG     = 14;

	localparam logic [1:0] MODE_WRITE  = 2'd0;
	localparam logic [1:0] MODE_SEARCH = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_FOUND  = 2'd1;
	localparam logic [1:0] STAT_NONE   = 2'd2;
	localparam logic [1:0] STAT_BEYOND = 2'd3;

	localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
	localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
	localparam logic [2:0] REG_START_X     = 3'd2;
	localparam logic [2:0] REG_START_Y     = 3'd3;
	localparam logic [2:0] REG_GOAL_X      = 3'd4;
	localparam logic [2:0] REG_GOAL_Y      = 3'd5;

	typedef struct packed {
		logic clr;
		logic en;
	} scan_ctl_t;

	function automatic logic [7:0] dir_dx(input logic [2:0] k);
		logic [7:0] r;
		unique case (k)
			3'd0, 3'd3, 3'd5: r = 8'hFF;
			3'd1, 3'd6:       r = 8'h00;
			default:          r = 8'h01;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] dir_dy(input logic [2:0] k);
		logic [7:0] r;
		unique case (k)
			3'd0, 3'd1, 3'd2: r = 8'hFF;
			3'd3, 3'd4:       r = 8'h00;
			default:          r = 8'h01;
		endcase
		return r;
	endfunction

	function automatic logic dir_diag(input logic [2:0] k);
		return (k == 3'd0) || (k == 3'd2) || (k == 3'd5) || (k == 3'd7);
	endfunction

	function automatic logic [15:0] octile(input logic [7:0] ax, input logic [7:0] ay,
		input logic [7:0] bx, input logic [7:0] by);
		logic [7:0] dx;
		logic [7:0] dy;
		logic [7:0] lo;
		logic [7:0] hi;
		dx = (ax > bx) ? ax - bx : bx - ax;
		dy = (ay > by) ? ay - by : by - ay;
		lo = (dx < dy) ? dx : dy;
		hi = (dx < dy) ? dy : dx;
		return 16'(lo) * 16'(COST_DIAG) + 16'(hi - lo) * 16'(COST_STRAIGHT);
	endfunction

endpackage

[src/gaps_open_scan.sv]
module gaps_open_scan #(
	parameter int AW = 8,
	parameter int GW = 12,
	parameter int OW = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  gaps_pkg::scan_ctl_t     ctl,
	input  logic [AW-1:0]           addr,
	input  logic [2*GW+OW+2:0]      pay,
	output logic                    found,
	output logic [AW-1:0]           best_addr,
	output logic [2*GW+OW+2:0]      best_pay
);

	logic              found_q;
	logic [AW-1:0]     addr_q;
	logic [2*GW+OW+2:0] pay_q;
	logic [GW-1:0]     g_in, h_in, g_b, h_b;
	logic [OW-1:0]     o_in, o_b;
	logic [GW:0]       f_in, f_b;
	logic              better;

	assign g_in = pay[2*GW+OW+2:GW+OW+3];
	assign h_in = pay[GW+OW+2:OW+3];
	assign o_in = pay[OW+2:3];
	assign g_b  = pay_q[2*GW+OW+2:GW+OW+3];
	assign h_b  = pay_q[GW+OW+2:OW+3];
	assign o_b  = pay_q[OW+2:3];
	assign f_in = {1'b0, g_in} + {1'b0, h_in};
	assign f_b  = {1'b0, g_b} + {1'b0, h_b};

	assign better = !found_q || (f_in < f_b) ||
		((f_in == f_b) && ((h_in < h_b) || ((h_in == h_b) && (o_in < o_b))));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clr) begin
			found_q <= 1'b0;
		end else if (ctl.en && better) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en && better && !ctl.clr) begin
			addr_q <= addr;
			pay_q  <= pay;
		end
	end

	assign found     = found_q;
	assign best_addr = addr_q;
	assign best_pay  = pay_q;

endmodule

[src/grid_astar_path_search_core.sv]
// channel  | ports                      | carries
// s        | s_tvalid s_tready s_tdata  | cell_x, cell_y, blocked, step_index; s_tuser mode
// m        | m_tvalid m_tready m_tdata  | path_length, step_x, step_y; m_tuser status
// cfg      | cfg_wr cfg_index cfg_data  | register writes, no wait
// Cell write and unused mode: result loaded in the accept cycle. Path read: loaded from S_PREAD.
// Search: a goal-cell check and a clear of the node memory, then per expansion an
// open-set scan over the node memory plus a neighbour update over the eight directions,
// then the path is walked twice, step by step; DEPTH = 2^(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)).
// After reset a pass over all DEPTH addresses clears the grid memory; no beat is taken meanwhile.
// A waiting result holds s_tready low while m_tready is low.
module grid_astar_path_search_core #(
	parameter int MAX_WIDTH  = gaps_pkg::MAX_WIDTH,
	parameter int MAX_HEIGHT = gaps_pkg::MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // cell_x[3:0] cell_y[7:4] blocked[8] step_index[16:9]
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // path_length[7:0] step_x[11:8] step_y[15:12]
	output logic [1:0]  m_tuser,   // status[1:0]
	input  logic        cfg_wr,
	input  logic [2:0]  cfg_index,
	input  logic [4:0]  cfg_data
);

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int AW    = XW + YW;
	localparam int DEPTH = 1 << AW;
	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int GW    = $clog2(14 * CELLS + 1);
	localparam int OW    = $clog2(CELLS);
	localparam int LW    = $clog2(CELLS + 1);
	localparam int PW    = 2 * GW + OW + 3;
	localparam int NW    = PW + 2;

	localparam logic [3:0] S_GCLR   = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_PREAD  = 4'd2;
	localparam logic [3:0] S_GOAL   = 4'd3;
	localparam logic [3:0] S_NCLR   = 4'd4;
	localparam logic [3:0] S_SINIT  = 4'd5;
	localparam logic [3:0] S_SCAN   = 4'd6;
	localparam logic [3:0] S_PICK   = 4'd7;
	localparam logic [3:0] S_NADDR  = 4'd8;
	localparam logic [3:0] S_NCHK   = 4'd9;
	localparam logic [3:0] S_WALK   = 4'd10;
	localparam logic [3:0] S_WALKNX = 4'd11;

	logic [4:0] gw_q, gh_q;
	logic [3:0] sx_q, sy_q, gx_q, gy_q;

	logic [3:0]    st_q, st_d;
	logic [AW:0]   ctr_q, ctr_d;
	logic [AW-1:0] cur_q, cur_d, n_q, n_d, walk_q, walk_d;
	logic [GW-1:0] cur_g_q, cur_g_d;
	logic [2:0]    k_q, k_d;
	logic [LW-1:0] seq_q, seq_d, len_q, len_d, idx_q, idx_d, slen_q, slen_d;
	logic          pass_q, pass_d, pok_q, pok_d;
	logic          rd_v_s1;
	logic [AW-1:0] rd_a_s1;

	logic          mv_q;
	logic [1:0]    mstat_q;
	logic [7:0]    mlen_q;
	logic [3:0]    mx_q, my_q;

	logic          ld;
	logic [1:0]    ld_stat;
	logic [7:0]    ld_len;
	logic [3:0]    ld_x, ld_y;

	logic [NW-1:0] node_mem [DEPTH];
	logic [NW-1:0] node_rd_q, node_wdata;
	logic [AW-1:0] node_raddr, node_waddr;
	logic          node_we;

	logic          grid_mem [DEPTH];
	logic          grid_rd_q, grid_wdata, grid_we;
	logic [AW-1:0] grid_raddr, grid_waddr;

	logic [AW-1:0] path_mem [DEPTH];
	logic [AW-1:0] path_rd_q, path_wdata, path_raddr, path_waddr;
	logic          path_we;

	gaps_pkg::scan_ctl_t sctl;
	logic          sc_found;
	logic [AW-1:0] sc_addr;
	logic [PW-1:0] sc_pay;

	logic [3:0]    in_x, in_y;
	logic          in_blk;
	logic [7:0]    in_idx;
	logic          acc;

	logic [6:0]    w_eff, h_eff;
	logic [AW-1:0] start_a, goal_a;
	logic [7:0]    cx8, cy8, nx8, ny8, wx8, wy8, px8, py8, qx8, qy8;
	logic          n_ok;
	logic [AW-1:0] n_addr, p_addr;
	logic [GW-1:0] ng, rd_g, rd_h, h_start, h_n;
	logic [OW-1:0] rd_o;
	logic [2:0]    rd_par;
	logic [LW-1:0] im1;
	logic [7:0]    slen_sh, len_sh, pr_x8, pr_y8;
	logic          search_ok;

	assign in_x   = s_tdata[3:0];
	assign in_y   = s_tdata[7:4];
	assign in_blk = s_tdata[8];
	assign in_idx = s_tdata[16:9];

	assign s_tready = (st_q == S_IDLE) && (!mv_q || m_tready);
	assign acc      = s_tvalid && s_tready;

	assign w_eff = (32'(gw_q) > MAX_WIDTH) ? 7'(MAX_WIDTH) : 7'(gw_q);
	assign h_eff = (32'(gh_q) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : 7'(gh_q);

	assign qx8     = 8'(sx_q);
	assign qy8     = 8'(sy_q);
	assign start_a = {qy8[YW-1:0], qx8[XW-1:0]};
	assign goal_a  = {pr_y8[YW-1:0], pr_x8[XW-1:0]};
	assign pr_x8   = 8'(gx_q);
	assign pr_y8   = 8'(gy_q);

	assign search_ok = (w_eff != 7'd0) && (h_eff != 7'd0) &&
		(7'(sx_q) < w_eff) && (7'(sy_q) < h_eff) &&
		(7'(gx_q) < w_eff) && (7'(gy_q) < h_eff);

	assign cx8    = 8'(cur_q[XW-1:0]);
	assign cy8    = 8'(cur_q[AW-1:XW]);
	assign nx8    = cx8 + gaps_pkg::dir_dx(k_q);
	assign ny8    = cy8 + gaps_pkg::dir_dy(k_q);
	assign n_ok   = !nx8[7] && !ny8[7] && (nx8 < 8'(w_eff)) && (ny8 < 8'(h_eff));
	assign n_addr = {ny8[YW-1:0], nx8[XW-1:0]};

	assign rd_g   = node_rd_q[2*GW+OW+2:GW+OW+3];
	assign rd_h   = node_rd_q[GW+OW+2:OW+3];
	assign rd_o   = node_rd_q[OW+2:3];
	assign rd_par = node_rd_q[2:0];

	assign wx8    = 8'(walk_q[XW-1:0]);
	assign wy8    = 8'(walk_q[AW-1:XW]);
	assign px8    = wx8 - gaps_pkg::dir_dx(rd_par);
	assign py8    = wy8 - gaps_pkg::dir_dy(rd_par);
	assign p_addr = {py8[YW-1:0], px8[XW-1:0]};

	assign ng = cur_g_q + (gaps_pkg::dir_diag(k_q) ? GW'(gaps_pkg::COST_DIAG)
		: GW'(gaps_pkg::COST_STRAIGHT));
	assign h_start = GW'(gaps_pkg::octile(qx8, qy8, pr_x8, pr_y8));
	assign h_n     = GW'(gaps_pkg::octile(8'(n_q[XW-1:0]), 8'(n_q[AW-1:XW]), pr_x8, pr_y8));

	assign im1     = idx_q - LW'(1);
	assign slen_sh = (32'(slen_q) > 32'd255) ? 8'hFF : 8'(slen_q);
	assign len_sh  = (32'(len_q) > 32'd255) ? 8'hFF : 8'(len_q);

	gaps_open_scan #(
		.AW (AW),
		.GW (GW),
		.OW (OW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (sctl),
		.addr      (rd_a_s1),
		.pay       (node_rd_q[PW-1:0]),
		.found     (sc_found),
		.best_addr (sc_addr),
		.best_pay  (sc_pay)
	);

	always_comb begin
		st_d    = st_q;
		ctr_d   = ctr_q;
		cur_d   = cur_q;
		cur_g_d = cur_g_q;
		n_d     = n_q;
		walk_d  = walk_q;
		k_d     = k_q;
		seq_d   = seq_q;
		len_d   = len_q;
		idx_d   = idx_q;
		slen_d  = slen_q;
		pass_d  = pass_q;
		pok_d   = pok_q;
		node_we    = 1'b0;
		node_waddr = '0;
		node_wdata = '0;
		node_raddr = '0;
		grid_we    = 1'b0;
		grid_waddr = '0;
		grid_wdata = 1'b0;
		grid_raddr = '0;
		path_we    = 1'b0;
		path_waddr = '0;
		path_wdata = '0;
		path_raddr = '0;
		sctl    = '0;
		ld      = 1'b0;
		ld_stat = gaps_pkg::STAT_OK;
		ld_len  = slen_sh;
		ld_x    = 4'd0;
		ld_y    = 4'd0;

		unique case (st_q)
			S_GCLR: begin
				grid_we    = 1'b1;
				grid_waddr = ctr_q[AW-1:0];
				ctr_d      = ctr_q + 1'b1;
				if (ctr_q[AW-1:0] == AW'(DEPTH - 1)) begin
					st_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (acc) begin
					unique case (s_tuser)
						gaps_pkg::MODE_WRITE: begin
							if ((32'(in_x) < MAX_WIDTH) && (32'(in_y) < MAX_HEIGHT)) begin
								grid_we    = 1'b1;
								grid_waddr = {YW'(in_y), XW'(in_x)};
								grid_wdata = in_blk;
							end
							ld = 1'b1;
						end
						gaps_pkg::MODE_SEARCH: begin
							slen_d = '0;
							if (search_ok) begin
								grid_raddr = goal_a;
								st_d       = S_GOAL;
							end else begin
								ld      = 1'b1;
								ld_stat = gaps_pkg::STAT_NONE;
								ld_len  = 8'd0;
							end
						end
						gaps_pkg::MODE_READ: begin
							path_raddr = AW'(in_idx);
							pok_d      = 32'(in_idx) < 32'(slen_q);
							st_d       = S_PREAD;
						end
						default: begin
							ld = 1'b1;
						end
					endcase
				end
			end
			S_PREAD: begin
				ld = 1'b1;
				if (pok_q) begin
					ld_x = 4'(8'(path_rd_q[XW-1:0]));
					ld_y = 4'(8'(path_rd_q[AW-1:XW]));
				end else begin
					ld_stat = gaps_pkg::STAT_BEYOND;
				end
				st_d = S_IDLE;
			end
			S_GOAL: begin
				if (grid_rd_q) begin
					ld      = 1'b1;
					ld_stat = gaps_pkg::STAT_NONE;
					ld_len  = 8'd0;
					st_d    = S_IDLE;
				end else begin
					ctr_d = '0;
					st_d  = S_NCLR;
				end
			end
			S_NCLR: begin
				node_we    = 1'b1;
				node_waddr = ctr_q[AW-1:0];
				ctr_d      = ctr_q + 1'b1;
				if (ctr_q[AW-1:0] == AW'(DEPTH - 1)) begin
					st_d = S_SINIT;
				end
			end
			S_SINIT: begin
				node_we    = 1'b1;
				node_waddr = start_a;
				node_wdata = {1'b1, 1'b0, GW'(0), h_start, OW'(0), 3'd0};
				seq_d      = LW'(1);
				ctr_d      = '0;
				sctl.clr   = 1'b1;
				st_d       = S_SCAN;
			end
			S_SCAN: begin
				if (ctr_q != (AW+1)'(DEPTH)) begin
					node_raddr = ctr_q[AW-1:0];
					ctr_d      = ctr_q + 1'b1;
				end else begin
					st_d = S_PICK;
				end
				sctl.en = rd_v_s1 && node_rd_q[NW-1];
			end
			S_PICK: begin
				if (!sc_found) begin
					ld      = 1'b1;
					ld_stat = gaps_pkg::STAT_NONE;
					ld_len  = 8'd0;
					st_d    = S_IDLE;
				end else begin
					node_we    = 1'b1;
					node_waddr = sc_addr;
					node_wdata = {1'b0, 1'b1, sc_pay};
					cur_d      = sc_addr;
					cur_g_d    = sc_pay[PW-1:GW+OW+3];
					if (sc_addr == goal_a) begin
						walk_d = goal_a;
						len_d  = '0;
						pass_d = 1'b0;
						st_d   = S_WALK;
					end else begin
						k_d  = 3'd0;
						st_d = S_NADDR;
					end
				end
			end
			S_NADDR: begin
				if (n_ok) begin
					node_raddr = n_addr;
					grid_raddr = n_addr;
					n_d        = n_addr;
					st_d       = S_NCHK;
				end else if (k_q == 3'd7) begin
					ctr_d    = '0;
					sctl.clr = 1'b1;
					st_d     = S_SCAN;
				end else begin
					k_d = k_q + 3'd1;
				end
			end
			S_NCHK: begin
				if (!grid_rd_q && !node_rd_q[NW-2]) begin
					if (!node_rd_q[NW-1]) begin
						node_we    = 1'b1;
						node_waddr = n_q;
						node_wdata = {1'b1, 1'b0, ng, h_n, OW'(seq_q), k_q};
						seq_d      = seq_q + LW'(1);
					end else if (ng < rd_g) begin
						node_we    = 1'b1;
						node_waddr = n_q;
						node_wdata = {1'b1, 1'b0, ng, rd_h, rd_o, k_q};
					end
				end
				if (k_q == 3'd7) begin
					ctr_d    = '0;
					sctl.clr = 1'b1;
					st_d     = S_SCAN;
				end else begin
					k_d  = k_q + 3'd1;
					st_d = S_NADDR;
				end
			end
			S_WALK: begin
				if (!pass_q) begin
					if ((walk_q == start_a) || (32'(len_q) >= CELLS)) begin
						pass_d = 1'b1;
						walk_d = goal_a;
						idx_d  = len_q;
					end else begin
						node_raddr = walk_q;
						st_d       = S_WALKNX;
					end
				end else if (idx_q == '0) begin
					slen_d  = len_q;
					ld      = 1'b1;
					ld_stat = gaps_pkg::STAT_FOUND;
					ld_len  = len_sh;
					st_d    = S_IDLE;
				end else begin
					node_raddr = walk_q;
					st_d       = S_WALKNX;
				end
			end
			S_WALKNX: begin
				if (!pass_q) begin
					len_d = len_q + LW'(1);
				end else begin
					path_we    = 1'b1;
					path_waddr = AW'(im1);
					path_wdata = walk_q;
					idx_d      = im1;
				end
				walk_d = p_addr;
				st_d   = S_WALK;
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_GCLR;
			ctr_q   <= '0;
			k_q     <= '0;
			seq_q   <= '0;
			len_q   <= '0;
			idx_q   <= '0;
			slen_q  <= '0;
			pass_q  <= 1'b0;
			rd_v_s1 <= 1'b0;
			mv_q    <= 1'b0;
			gw_q    <= 5'd16;
			gh_q    <= 5'd16;
			sx_q    <= 4'd0;
			sy_q    <= 4'd0;
			gx_q    <= 4'd15;
			gy_q    <= 4'd15;
		end else begin
			st_q    <= st_d;
			ctr_q   <= ctr_d;
			k_q     <= k_d;
			seq_q   <= seq_d;
			len_q   <= len_d;
			idx_q   <= idx_d;
			slen_q  <= slen_d;
			pass_q  <= pass_d;
			rd_v_s1 <= (st_q == S_SCAN) && (ctr_q != (AW+1)'(DEPTH));
			if (ld) begin
				mv_q <= 1'b1;
			end else if (m_tready) begin
				mv_q <= 1'b0;
			end
			if (cfg_wr) begin
				unique case (cfg_index)
					gaps_pkg::REG_GRID_WIDTH:  gw_q <= cfg_data;
					gaps_pkg::REG_GRID_HEIGHT: gh_q <= cfg_data;
					gaps_pkg::REG_START_X:     sx_q <= cfg_data[3:0];
					gaps_pkg::REG_START_Y:     sy_q <= cfg_data[3:0];
					gaps_pkg::REG_GOAL_X:      gx_q <= cfg_data[3:0];
					gaps_pkg::REG_GOAL_Y:      gy_q <= cfg_data[3:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q   <= cur_d;
		cur_g_q <= cur_g_d;
		n_q     <= n_d;
		walk_q  <= walk_d;
		pok_q   <= pok_d;
		rd_a_s1 <= node_raddr;
		if (ld) begin
			mstat_q <= ld_stat;
			mlen_q  <= ld_len;
			mx_q    <= ld_x;
			my_q    <= ld_y;
		end
	end

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[node_waddr] <= node_wdata;
		end
		node_rd_q <= node_mem[node_raddr];
	end

	always_ff @(posedge clk) begin
		if (grid_we) begin
			grid_mem[grid_waddr] <= grid_wdata;
		end
		grid_rd_q <= grid_mem[grid_raddr];
	end

	always_ff @(posedge clk) begin
		if (path_we) begin
			path_mem[path_waddr] <= path_wdata;
		end
		path_rd_q <= path_mem[path_raddr];
	end

	assign m_tvalid = mv_q;
	assign m_tuser  = mstat_q;
	assign m_tdata  = {my_q, mx_q, mlen_q};

endmodule
